// ===== hdl/pbg_pkg.sv =====
`timescale 1ns / 1ps
// Package for the playout buffer gate: register indexes, action codes,
// configuration, state and result structs. No dependencies.
package pbg_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CYCLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REMAINDER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREFILL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REBUFFER   = 3'd4;
    localparam int unsigned CFG_DATA_W = 24;

    // Action codes reported with each result
    localparam logic [2:0] ACT_EMPTY      = 3'd0;
    localparam logic [2:0] ACT_INACTIVE   = 3'd1;
    localparam logic [2:0] ACT_PREFILL    = 3'd2;
    localparam logic [2:0] ACT_REBUFFER   = 3'd3;
    localparam logic [2:0] ACT_FULL_POP   = 3'd4;
    localparam logic [2:0] ACT_UNDERRUN   = 3'd5;

    typedef struct packed {
        logic [15:0] base_cycle_bytes;
        logic [6:0]  frame_bytes;
        logic [5:0]  cycle_remainder;
        logic [23:0] prefill_bytes;
        logic [23:0] rebuffer_target_bytes;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  frac_accumulator;
        logic        steady_flag;
        logic        prefill_done_flag;
        logic        rebuffering_flag;
        logic [23:0] armed_threshold;
        logic [31:0] active_cycles;
        logic [31:0] silence_cycles;
        logic [31:0] pop_cycles;
        logic [31:0] underrun_events;
        logic [47:0] bytes_popped;
    } state_t;

    typedef struct packed {
        logic [16:0] size_bytes;
        logic [2:0]  action;
        logic [16:0] real_bytes;
        logic [31:0] cycle_count;
        logic [31:0] silent_count;
        logic [31:0] real_count;
        logic [31:0] underrun_count;
        logic [47:0] popped_total;
    } result_t;

endpackage

// ===== hdl/pbg_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the playout buffer gate.
// Standalone; no package needed.
interface pbg_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] ring_available;
    logic        active;

    modport source (output valid, output ring_available, output active, input ready);
    modport sink   (input valid, input ring_available, input active, output ready);
endinterface

interface pbg_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] size_bytes;
    logic [2:0]  action;
    logic [16:0] real_bytes;
    logic [31:0] cycle_count;
    logic [31:0] silent_count;
    logic [31:0] real_count;
    logic [31:0] underrun_count;
    logic [47:0] popped_total;

    modport source (output valid, output size_bytes, output action, output real_bytes,
                    output cycle_count, output silent_count, output real_count,
                    output underrun_count, output popped_total, input ready);
    modport sink   (input valid, input size_bytes, input action, input real_bytes,
                    input cycle_count, input silent_count, input real_count,
                    input underrun_count, input popped_total, output ready);
endinterface

// ===== hdl/pbg_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the playout buffer gate.
// Depends on pbg_pkg.
module pbg_cfg
    import pbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  clear_state
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic hit;

    // Index decode; writes beyond the list are dropped and clear nothing
    always_comb
    begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_CYCLE:
                begin
                    cfg_next.base_cycle_bytes = cfg_data[15:0];
                    hit = 1'b1;
                end
                REG_FRAME:
                begin
                    cfg_next.frame_bytes = cfg_data[6:0];
                    hit = 1'b1;
                end
                REG_REMAINDER:
                begin
                    cfg_next.cycle_remainder = cfg_data[5:0];
                    hit = 1'b1;
                end
                REG_PREFILL:
                begin
                    cfg_next.prefill_bytes = cfg_data[23:0];
                    hit = 1'b1;
                end
                REG_REBUFFER:
                begin
                    cfg_next.rebuffer_target_bytes = cfg_data[23:0];
                    hit = 1'b1;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg         = cfg_reg;
    assign clear_state = hit;

endmodule

// ===== hdl/pbg_decide.sv =====
`timescale 1ns / 1ps
// Per-cycle gate decision: compensation frame, silence/pop cascade, counters.
// Pure combinational; depends on pbg_pkg.
module pbg_decide
    import pbg_pkg::*;
(
    input  cfg_t        cfg,
    input  state_t      cur,
    input  logic [23:0] ring_available,
    input  logic        active,
    output state_t      nxt,
    output result_t     res
);

    logic [7:0]  acc_sum;
    logic [16:0] want;
    logic [16:0] real_b;
    logic [2:0]  act_code;
    logic        decided;
    logic        have_want;

    always_comb
    begin
        nxt      = cur;
        want     = {1'b0, cfg.base_cycle_bytes};
        real_b   = '0;
        act_code = ACT_EMPTY;
        decided  = 1'b0;
        acc_sum  = {1'b0, cur.frac_accumulator} + {2'b00, cfg.cycle_remainder};

        // Fractional remainder: add one extra frame once a frame has built up
        if (cfg.frame_bytes != 7'd0 && cfg.cycle_remainder != 6'd0)
        begin
            if (acc_sum >= {1'b0, cfg.frame_bytes})
            begin
                acc_sum = acc_sum - {1'b0, cfg.frame_bytes};
                want    = want + {10'd0, cfg.frame_bytes};
            end
            nxt.frac_accumulator = acc_sum[6:0];
        end

        // 24-bit fill compares against the 17-bit request
        have_want = ring_available >= {7'd0, want};

        if (!active)
        begin
            nxt.steady_flag = 1'b0;
            act_code        = ACT_INACTIVE;
        end
        else if (want == 17'd0)
        begin
            act_code = ACT_EMPTY;
        end
        else
        begin
            nxt.active_cycles = cur.active_cycles + 32'd1;

            // Steady fast path
            if (cur.steady_flag)
            begin
                if (have_want)
                begin
                    real_b   = want;
                    act_code = ACT_FULL_POP;
                    decided  = 1'b1;
                end
                else
                begin
                    nxt.steady_flag = 1'b0;
                end
            end

            // Prefill gate
            if (!decided && !cur.prefill_done_flag)
            begin
                if (cfg.prefill_bytes == 24'd0 || ring_available >= cfg.prefill_bytes)
                    nxt.prefill_done_flag = 1'b1;
                else
                begin
                    act_code = ACT_PREFILL;
                    decided  = 1'b1;
                end
            end

            // Rebuffer gate
            if (!decided && cur.rebuffering_flag)
            begin
                if (ring_available >= cur.armed_threshold)
                    nxt.rebuffering_flag = 1'b0;
                else
                begin
                    act_code = ACT_REBUFFER;
                    decided  = 1'b1;
                end
            end

            // Pop: full cycle, or what is there on underrun
            if (!decided)
            begin
                if (!have_want)
                begin
                    nxt.armed_threshold  = cfg.rebuffer_target_bytes;
                    nxt.rebuffering_flag = 1'b1;
                    nxt.underrun_events  = cur.underrun_events + 32'd1;
                    real_b               = ring_available[16:0];
                    act_code             = ACT_UNDERRUN;
                end
                else
                begin
                    real_b          = want;
                    nxt.steady_flag = 1'b1;
                    act_code        = ACT_FULL_POP;
                end
            end

            // Diagnostic counters
            if (act_code == ACT_PREFILL || act_code == ACT_REBUFFER)
                nxt.silence_cycles = cur.silence_cycles + 32'd1;
            else
            begin
                nxt.bytes_popped = cur.bytes_popped + {31'd0, real_b};
                nxt.pop_cycles   = cur.pop_cycles + 32'd1;
            end
        end

        res.size_bytes     = want;
        res.action         = act_code;
        res.real_bytes     = real_b;
        res.cycle_count    = nxt.active_cycles;
        res.silent_count   = nxt.silence_cycles;
        res.real_count     = nxt.pop_cycles;
        res.underrun_count = nxt.underrun_events;
        res.popped_total   = nxt.bytes_popped;
    end

endmodule

// ===== hdl/pbg_out_reg.sv =====
`timescale 1ns / 1ps
// Result register with valid/ready toward the output channel.
// Depends on pbg_pkg and pbg_out_if.
module pbg_out_reg
    import pbg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  result_t  res,
    output logic     can_load,
    pbg_out_if.source out_ch
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or when the held result leaves this cycle
    assign can_load   = !valid_reg || out_ch.ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.size_bytes     = data_reg.size_bytes;
    assign out_ch.action         = data_reg.action;
    assign out_ch.real_bytes     = data_reg.real_bytes;
    assign out_ch.cycle_count    = data_reg.cycle_count;
    assign out_ch.silent_count   = data_reg.silent_count;
    assign out_ch.real_count     = data_reg.real_count;
    assign out_ch.underrun_count = data_reg.underrun_count;
    assign out_ch.popped_total   = data_reg.popped_total;

endmodule

// ===== hdl/playout_buffer_gate.sv =====
`timescale 1ns / 1ps
// Playout buffer gate top level. The result is valid in the cycle after its input.
// Throughput: one transaction per cycle unless stalled; state regs close the loop.
// The input is ready whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous) clears configuration, state and result valid.
// A configuration write to a listed register clears all gate state.
// Depends on pbg_pkg, pbg_if, pbg_cfg, pbg_decide, pbg_out_reg.
module playout_buffer_gate
    import pbg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pbg_in_if.sink                in_ch,
    pbg_out_if.source             out_ch
);

    cfg_t    cfg;
    logic    clear_state;
    state_t  state_reg;
    state_t  state_next;
    state_t  step_state;
    result_t res;
    logic    can_load;
    logic    accept;

    pbg_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .clear_state (clear_state)
    );

    pbg_decide u_decide (
        .cfg            (cfg),
        .cur            (state_reg),
        .ring_available (in_ch.ring_available),
        .active         (in_ch.active),
        .nxt            (step_state),
        .res            (res)
    );

    pbg_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res      (res),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

    assign in_ch.ready = can_load;
    assign accept      = in_ch.valid && can_load;

    // Gate state: cleared by a register write, advanced per transaction
    always_comb
    begin
        if (clear_state)
            state_next = '0;
        else if (accept)
            state_next = step_state;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/pbg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for playout_buffer_gate, attached by bind.
// Depends on pbg_pkg.
module pbg_checker
    import pbg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  action,
    input logic [16:0] size_bytes,
    input logic [16:0] real_bytes
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(real_bytes))
        else $error("stalled result changed");

    // A stalled result register blocks new transactions
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while result stalled");

    // Silence actions take nothing from the ring
    a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_EMPTY || action == ACT_INACTIVE ||
                      action == ACT_PREFILL || action == ACT_REBUFFER) |-> real_bytes == 17'd0)
        else $error("silence cycle with ring bytes");

    // Full pop takes the whole cycle, underrun strictly less
    a_pop_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_FULL_POP || action == ACT_UNDERRUN) |->
        ((action == ACT_FULL_POP) ? (real_bytes == size_bytes) : (real_bytes < size_bytes)))
        else $error("pop size inconsistent with action");

endmodule

bind playout_buffer_gate pbg_checker u_pbg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .action     (out_ch.action),
    .size_bytes (out_ch.size_bytes),
    .real_bytes (out_ch.real_bytes)
);
